### hdl/huffman_codebook_encoder_assert.svh
// Assertion macros for the Huffman codebook encoder.
// Used by huffman_codebook_encoder.sv; expects clk and rst in scope.
`ifndef HUFFMAN_CODEBOOK_ENCODER_ASSERT_SVH
`define HUFFMAN_CODEBOOK_ENCODER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define HCE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define HCE_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define HCE_ASSERT(lbl, prop, msg)
`define HCE_NEVER(lbl, expr, msg)
`endif
`endif

### hdl/hce_pkg.sv
// Shared types and constants of the Huffman codebook encoder.
// No dependencies.
package hce_pkg;

  localparam int CODE_W = 63;
  localparam int LEN_W  = 6;
  localparam int OP_W   = 2;
  localparam int SYM_W  = 8;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_COUNT  = 2'd1,
    OP_BUILD  = 2'd2,
    OP_ENCODE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_NO_BUILD = 2'd2,
    STAT_ABSENT   = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    ST_RCLR,
    ST_IDLE,
    ST_CLR,
    ST_CNT_RD,
    ST_CNT_WR,
    ST_ENC_RD,
    ST_LD_RD,
    ST_LD_WR,
    ST_LD_END,
    ST_MG_CHK,
    ST_SCAN,
    ST_SC_DRAIN,
    ST_MG_W1,
    ST_MG_W2,
    ST_WK_START,
    ST_WK_STEP,
    ST_WK_DATA,
    ST_BLD_OK,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic take;
    logic idx_clr;
    logic idx_inc;
    logic sel_idx;
    logic cnt_clr;
    logic cnt_inc;
    logic load_wr;
    logic merge_init;
    logic scan_init;
    logic scan_issue;
    logic merge_a;
    logic merge_b;
    logic walk_init;
    logic par_rd;
    logic walk_adv;
    logic code_wr;
    logic enc_rd;
    logic build_ok;
    logic build_fail;
    logic clr_valid;
    logic res_load;
  } cmd_t;

  typedef struct packed {
    logic idx_last;
    logic scan_last;
    logic none_present;
    logic merge_done;
    logic sym_present;
    logic at_root;
    logic out_full;
  } stat_t;

endpackage

### hdl/hce_ctrl.sv
// Sequencer of the Huffman codebook encoder: one state machine that takes one word at a time.
// Depends on hce_pkg.
module hce_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       opcode,
  input  logic             out_ready,
  input  hce_pkg::stat_t   stat,
  output hce_pkg::cmd_t    cmd
);

  hce_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hce_pkg::ST_RCLR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      hce_pkg::ST_RCLR: begin
        cmd.cnt_clr = 1'b1;
        cmd.sel_idx = 1'b1;
        if (stat.idx_last) begin
          state_next = hce_pkg::ST_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      hce_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take    = 1'b1;
          cmd.idx_clr = 1'b1;
          case (hce_pkg::op_t'(opcode))
            hce_pkg::OP_CLEAR: begin
              cmd.clr_valid = 1'b1;
              state_next    = hce_pkg::ST_CLR;
            end
            hce_pkg::OP_COUNT:  state_next = hce_pkg::ST_CNT_RD;
            hce_pkg::OP_BUILD:  state_next = hce_pkg::ST_LD_RD;
            default:            state_next = hce_pkg::ST_ENC_RD;
          endcase
        end
      end
      hce_pkg::ST_CLR: begin
        cmd.cnt_clr = 1'b1;
        cmd.sel_idx = 1'b1;
        if (stat.idx_last) begin
          state_next = hce_pkg::ST_FIN;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      hce_pkg::ST_CNT_RD: state_next = hce_pkg::ST_CNT_WR;
      hce_pkg::ST_CNT_WR: begin
        cmd.cnt_inc = 1'b1;
        state_next  = hce_pkg::ST_FIN;
      end
      hce_pkg::ST_ENC_RD: begin
        cmd.enc_rd = 1'b1;
        state_next = hce_pkg::ST_FIN;
      end
      hce_pkg::ST_LD_RD: begin
        cmd.sel_idx = 1'b1;
        state_next  = hce_pkg::ST_LD_WR;
      end
      hce_pkg::ST_LD_WR: begin
        cmd.sel_idx = 1'b1;
        cmd.load_wr = 1'b1;
        if (stat.idx_last) begin
          state_next = hce_pkg::ST_LD_END;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = hce_pkg::ST_LD_RD;
        end
      end
      hce_pkg::ST_LD_END: begin
        if (stat.none_present) begin
          cmd.build_fail = 1'b1;
          state_next     = hce_pkg::ST_FIN;
        end else begin
          cmd.merge_init = 1'b1;
          state_next     = hce_pkg::ST_MG_CHK;
        end
      end
      hce_pkg::ST_MG_CHK: begin
        cmd.idx_clr = 1'b1;
        if (stat.merge_done) begin
          state_next = hce_pkg::ST_WK_START;
        end else begin
          cmd.scan_init = 1'b1;
          state_next    = hce_pkg::ST_SCAN;
        end
      end
      hce_pkg::ST_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (stat.scan_last) begin
          state_next = hce_pkg::ST_SC_DRAIN;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      hce_pkg::ST_SC_DRAIN: state_next = hce_pkg::ST_MG_W1;
      hce_pkg::ST_MG_W1: begin
        cmd.merge_a = 1'b1;
        state_next  = hce_pkg::ST_MG_W2;
      end
      hce_pkg::ST_MG_W2: begin
        cmd.merge_b = 1'b1;
        state_next  = hce_pkg::ST_MG_CHK;
      end
      hce_pkg::ST_WK_START: begin
        if (stat.sym_present) begin
          cmd.walk_init = 1'b1;
          state_next    = hce_pkg::ST_WK_STEP;
        end else if (stat.idx_last) begin
          state_next = hce_pkg::ST_BLD_OK;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      hce_pkg::ST_WK_STEP: begin
        if (stat.at_root) begin
          cmd.code_wr = 1'b1;
          if (stat.idx_last) begin
            state_next = hce_pkg::ST_BLD_OK;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = hce_pkg::ST_WK_START;
          end
        end else begin
          cmd.par_rd = 1'b1;
          state_next = hce_pkg::ST_WK_DATA;
        end
      end
      hce_pkg::ST_WK_DATA: begin
        cmd.walk_adv = 1'b1;
        state_next   = hce_pkg::ST_WK_STEP;
      end
      hce_pkg::ST_BLD_OK: begin
        cmd.build_ok = 1'b1;
        state_next   = hce_pkg::ST_FIN;
      end
      hce_pkg::ST_FIN: begin
        if (!stat.out_full || out_ready) begin
          cmd.res_load = 1'b1;
          state_next   = hce_pkg::ST_IDLE;
        end
      end
      default: state_next = hce_pkg::ST_IDLE;
    endcase
  end

endmodule

### hdl/hce_dpath.sv
// Datapath of the Huffman codebook encoder: histogram, tree and code memories,
// the two-lightest scan, the leaf-to-root walk and the output register. Uses hce_pkg.
module hce_dpath #(
  parameter int SYMBOLS    = 256,
  parameter int COUNT_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [1:0]                   opcode,
  input  logic [hce_pkg::SYM_W-1:0]    data_byte,
  input  logic                         out_ready,
  input  hce_pkg::cmd_t                cmd,
  output hce_pkg::stat_t               stat,
  output logic                         out_valid,
  output logic [hce_pkg::CODE_W-1:0]   code_bits,
  output logic [hce_pkg::LEN_W-1:0]    code_length,
  output logic [1:0]                   status
);

  localparam int NODES = 2 * SYMBOLS - 1;
  localparam int NW    = $clog2(NODES);
  localparam int SW    = $clog2(SYMBOLS);
  localparam int PCW   = $clog2(SYMBOLS + 1);
  localparam int WW    = COUNT_BITS + SW + 1;
  localparam int CW    = hce_pkg::CODE_W;
  localparam int LW    = hce_pkg::LEN_W;

  logic [COUNT_BITS-1:0] cnt_mem [SYMBOLS];
  logic [WW-1:0]         wgt_mem [NODES];
  logic [NW:0]           par_mem [NODES];
  logic [CW-1:0]         code_mem [SYMBOLS];
  logic [LW-1:0]         len_mem [SYMBOLS];

  hce_pkg::op_t          op_q;
  logic [hce_pkg::SYM_W-1:0] sym_q;
  logic [NW-1:0]         idx, next_node, root, node;
  logic [PCW-1:0]        present_cnt, merges_left;
  logic [NODES-1:0]      active;
  logic [SYMBOLS-1:0]    present;
  logic                  codes_valid;
  logic [COUNT_BITS-1:0] cnt_q;
  logic [WW-1:0]         rd_w, best_w, sec_w;
  logic [NW-1:0]         best_idx, sec_idx, rd_idx;
  logic                  best_ok, sec_ok, rd_v, rd_act;
  logic [NW:0]           par_q;
  logic [CW-1:0]         code_acc, code_q;
  logic [LW-1:0]         len_acc, len_q;

  logic [SW-1:0]         sym_s, idx_s, cnt_addr;
  logic                  sym_ok;
  logic [CW-1:0]         res_code;
  logic [LW-1:0]         res_len;
  hce_pkg::status_t      res_stat;

  assign sym_s    = sym_q[SW-1:0];
  assign idx_s    = idx[SW-1:0];
  assign sym_ok   = {1'b0, sym_q} < (hce_pkg::SYM_W + 1)'(SYMBOLS);
  assign cnt_addr = cmd.sel_idx ? idx_s : sym_s;

  // Histogram: read every cycle, write on clear or increment
  always_ff @(posedge clk) begin
    cnt_q <= cnt_mem[cnt_addr];
    if (cmd.cnt_clr) begin
      cnt_mem[cnt_addr] <= '0;
    end else if (cmd.cnt_inc && sym_ok) begin
      cnt_mem[cnt_addr] <= (&cnt_q) ? cnt_q : cnt_q + COUNT_BITS'(1);
    end
  end

  // Node weights
  always_ff @(posedge clk) begin
    rd_w <= wgt_mem[idx];
    if (cmd.load_wr) begin
      wgt_mem[idx] <= WW'(cnt_q);
    end else if (cmd.merge_a) begin
      wgt_mem[next_node] <= best_w + sec_w;
    end
  end

  // Parent link and side
  always_ff @(posedge clk) begin
    if (cmd.par_rd) begin
      par_q <= par_mem[node];
    end
    if (cmd.merge_a) begin
      par_mem[best_idx] <= {next_node, 1'b0};
    end else if (cmd.merge_b) begin
      par_mem[sec_idx] <= {next_node, 1'b1};
    end
  end

  // Code and length store
  always_ff @(posedge clk) begin
    if (cmd.enc_rd) begin
      code_q <= code_mem[sym_s];
      len_q  <= len_mem[sym_s];
    end
    if (cmd.code_wr) begin
      code_mem[idx_s] <= code_acc;
      len_mem[idx_s]  <= len_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx         <= '0;
      rd_v        <= 1'b0;
      codes_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + NW'(1);
      end
      rd_v <= cmd.scan_issue;
      if (cmd.clr_valid || cmd.build_fail) begin
        codes_valid <= 1'b0;
      end else if (cmd.build_ok) begin
        codes_valid <= 1'b1;
      end
      if (cmd.res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_q  <= hce_pkg::op_t'(opcode);
      sym_q <= data_byte;
      if (hce_pkg::op_t'(opcode) == hce_pkg::OP_BUILD) begin
        present_cnt <= '0;
      end
    end
    // Leaf load: one symbol per pass through the load read and load write states
    if (cmd.load_wr) begin
      active[idx]    <= (cnt_q != '0);
      present[idx_s] <= (cnt_q != '0);
      if (cnt_q != '0) begin
        present_cnt <= present_cnt + PCW'(1);
        root        <= idx;
      end
    end
    if (cmd.merge_init) begin
      next_node   <= NW'(SYMBOLS);
      merges_left <= present_cnt - PCW'(1);
    end
    // Two-lightest scan; strict compare keeps the lower node on a tie
    if (cmd.scan_issue) begin
      rd_idx <= idx;
      rd_act <= active[idx];
    end
    if (cmd.scan_init) begin
      best_ok <= 1'b0;
      sec_ok  <= 1'b0;
    end else if (rd_v && rd_act) begin
      if (!best_ok || rd_w < best_w) begin
        sec_ok   <= best_ok;
        sec_w    <= best_w;
        sec_idx  <= best_idx;
        best_ok  <= 1'b1;
        best_w   <= rd_w;
        best_idx <= rd_idx;
      end else if (!sec_ok || rd_w < sec_w) begin
        sec_ok  <= 1'b1;
        sec_w   <= rd_w;
        sec_idx <= rd_idx;
      end
    end
    if (cmd.merge_a) begin
      active[best_idx]  <= 1'b0;
      active[sec_idx]   <= 1'b0;
      active[next_node] <= 1'b1;
    end
    if (cmd.merge_b) begin
      root        <= next_node;
      next_node   <= next_node + NW'(1);
      merges_left <= merges_left - PCW'(1);
    end
    // Leaf-to-root walk; cap the length at the code width
    if (cmd.walk_init) begin
      node     <= idx;
      code_acc <= '0;
      len_acc  <= '0;
    end else if (cmd.walk_adv) begin
      node <= par_q[NW:1];
      if (len_acc < LW'(CW)) begin
        code_acc <= code_acc | (CW'(par_q[0]) << len_acc);
        len_acc  <= len_acc + LW'(1);
      end
    end
  end

  always_comb begin
    res_code = '0;
    res_len  = '0;
    res_stat = hce_pkg::STAT_OK;
    case (op_q)
      hce_pkg::OP_BUILD: begin
        if (present_cnt == '0) begin
          res_stat = hce_pkg::STAT_EMPTY;
        end
      end
      hce_pkg::OP_ENCODE: begin
        if (!codes_valid) begin
          res_stat = hce_pkg::STAT_NO_BUILD;
        end else if (!sym_ok || !present[sym_s]) begin
          res_stat = hce_pkg::STAT_ABSENT;
        end else begin
          res_code = code_q;
          res_len  = len_q;
        end
      end
      default: res_stat = hce_pkg::STAT_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      code_bits   <= res_code;
      code_length <= res_len;
      status      <= res_stat;
    end
  end

  assign stat.idx_last     = (idx == NW'(SYMBOLS - 1));
  assign stat.scan_last    = (idx == next_node - NW'(1));
  assign stat.none_present = (present_cnt == '0);
  assign stat.merge_done   = (merges_left == '0);
  assign stat.sym_present  = present[idx_s];
  assign stat.at_root      = (node == root);
  assign stat.out_full     = out_valid;

endmodule

### hdl/huffman_codebook_encoder.sv
// Byte Huffman codebook encoder: top level joining sequencer and datapath.
// Throughput: one word at a time; in_ready is high only while the sequencer is idle.
// Reset: synchronous; a clearing pass over all SYMBOLS entries zeroes the histogram with in_ready low.
// Depends on hce_pkg, hce_ctrl, hce_dpath and huffman_codebook_encoder_assert.svh.
`include "huffman_codebook_encoder_assert.svh"
module huffman_codebook_encoder #(
  parameter int SYMBOLS    = 256,
  parameter int COUNT_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [hce_pkg::OP_W-1:0]   opcode,
  input  logic [hce_pkg::SYM_W-1:0]  data_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [hce_pkg::CODE_W-1:0] code_bits,
  output logic [hce_pkg::LEN_W-1:0]  code_length,
  output logic [1:0]                 status
);

  // Command and status bundles between sequencer and datapath
  hce_pkg::cmd_t  cmd;
  hce_pkg::stat_t stat;

  // Sequencer: accept a word in idle, step through its phases, hand the
  // result to the output register and return to idle
  hce_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: memories, scan, walk and the output register that holds a
  // finished word while the next one is accepted
  hce_dpath #(
    .SYMBOLS    (SYMBOLS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .opcode      (opcode),
    .data_byte   (data_byte),
    .out_ready   (out_ready),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .code_bits   (code_bits),
    .code_length (code_length),
    .status      (status)
  );

  // Never overwrite a result word that has not been taken
  `HCE_NEVER(a_no_overwrite, cmd.res_load && out_valid && !out_ready, "result overwritten")
  // Every accept takes the sequencer out of idle: no accept right after an accept
  `HCE_ASSERT(a_one_at_a_time, (in_valid && in_ready) |=> !in_ready, "back-to-back accept")
  // A loaded result is presented in the next cycle
  `HCE_ASSERT(a_result_shown, cmd.res_load |=> out_valid, "result word not presented")

endmodule
